[rtl/rws_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// weighted reservoir sampler. No dependencies.
`default_nettype none

package rws_pkg;

  localparam int ID_W      = 16;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 8;
  localparam int RND_W     = 16;
  localparam int PROD_W    = CNT_W + VAL_W;
  localparam int REM_W     = PROD_W + 1;
  localparam int DIV_W     = VAL_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int MIS_W     = FRAC_BITS + 1;

  typedef enum logic [0:0] {
    CFG_EMITTER_COUNT = 1'b0,
    CFG_BSDF_COUNT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_MIS,
    DIV_RATE,
    DIV_CW
  } div_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_MIS,
    S_MIS_WAIT,
    S_SCALE,
    S_RATE,
    S_RATE_WAIT,
    S_ACC,
    S_CMP,
    S_UPD,
    S_FIN,
    S_CW_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    load_prod;
    logic    load_mis_one;
    logic    load_mis_div;
    logic    load_scaled;
    logic    div_start;
    div_op_t div_op;
    logic    load_rate;
    logic    load_sum;
    logic    load_cmp;
    logic    update;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic a_zero;
    logic b_zero;
    logic div_busy;
    logic rate_zero;
    logic last;
    logic keep_ok;
  } status_t;

endpackage

`default_nettype wire

[rtl/rws_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on rws_pkg.
`default_nettype none

module rws_divider
  import rws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [REM_W-1:0]  rem_init,
  input  wire logic [REM_W-1:0]  divisor,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [STEP_W-1:0] steps,
  output logic                   busy,
  output logic [DIV_W-1:0]       quotient
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  den_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  quot_r;
  logic [REM_W:0]    rem_sh;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign rem_sh  = {rem_r, num_r[DIV_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge      = ~diff[REM_W+1];
  assign rem_nxt = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem_init;
      den_r  <= divisor;
      num_r  <= dividend;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      num_r  <= {num_r[DIV_W-2:0], 1'b0};
      quot_r <= {quot_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

[rtl/rws_datapath.sv]
// Datapath of the reservoir sampler: configuration, candidate registers,
// multipliers, shared divider, reservoir state and result register.
// Depends on rws_pkg and rws_divider.
`default_nettype none

module rws_datapath
  import rws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_technique,
  input  wire logic             in_candidate_valid,
  input  wire logic [VAL_W-1:0] in_own_pdf,
  input  wire logic [VAL_W-1:0] in_other_pdf,
  input  wire logic             in_is_delta,
  input  wire logic [VAL_W-1:0] in_target_value,
  input  wire logic [ID_W-1:0]  in_candidate_id,
  input  wire logic [RND_W-1:0] in_random_fraction,
  input  wire logic             in_last,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic [ID_W-1:0]       out_chosen_id,
  output logic                  out_chosen_valid,
  output logic [VAL_W-1:0]      out_contribution_weight,
  output logic [VAL_W-1:0]      out_total_weight
);

  logic [CNT_W-1:0] emit_cnt_r, bsdf_cnt_r;

  logic             tech_r, cand_r, delta_r, last_r;
  logic [VAL_W-1:0] own_r, other_r, target_r;
  logic [ID_W-1:0]  id_r;
  logic [RND_W-1:0] rnd_r;

  logic [PROD_W-1:0]      a_r, b_r;
  logic [MIS_W-1:0]       mis_r;
  logic [VAL_W-1:0]       scaled_r, rate_r, sum_r;
  logic [RND_W+VAL_W-1:0] cmp_r;

  logic [VAL_W-1:0] ws_r, ws_nxt;
  logic [ID_W-1:0]  kept_id_r, kept_id_nxt;
  logic [VAL_W-1:0] kept_target_r, kept_target_nxt;
  logic             kept_valid_r, kept_valid_nxt;

  logic [ID_W-1:0]  out_id_r;
  logic             out_ok_r;
  logic [VAL_W-1:0] out_cw_r, out_tw_r;

  logic [CNT_W-1:0]       n_own, n_other;
  logic [VAL_W-1:0]       other_eff;
  logic [VAL_W+MIS_W-1:0] mis_prod;
  logic [VAL_W:0]         sum_ext;
  logic                   replace;
  logic                   keep_ok;
  logic [VAL_W-1:0]       cw_val;

  logic [REM_W-1:0]  div_rem_init, div_divisor;
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [STEP_W-1:0] div_steps;
  logic              div_busy;

  assign n_own     = tech_r ? bsdf_cnt_r : emit_cnt_r;
  assign n_other   = tech_r ? emit_cnt_r : bsdf_cnt_r;
  assign other_eff = (tech_r && delta_r) ? '0 : other_r;
  assign mis_prod  = (VAL_W+MIS_W)'(mis_r) * (VAL_W+MIS_W)'(target_r);
  assign sum_ext   = {1'b0, ws_r} + {1'b0, rate_r};
  assign replace   = cmp_r < {rate_r, {RND_W{1'b0}}};
  assign keep_ok   = kept_valid_r && (kept_target_r != '0);
  assign cw_val    = (|div_quot[DIV_W-1:VAL_W]) ? '1 : div_quot[VAL_W-1:0];

  always_comb begin
    unique case (cmd.div_op)
      DIV_MIS: begin
        div_rem_init = {1'b0, a_r};
        div_divisor  = {1'b0, a_r} + {1'b0, b_r};
        div_dividend = '0;
        div_steps    = STEP_W'(FRAC_BITS);
      end
      DIV_RATE: begin
        div_rem_init = '0;
        div_divisor  = REM_W'(n_own);
        div_dividend = {scaled_r, {FRAC_BITS{1'b0}}};
        div_steps    = STEP_W'(VAL_W);
      end
      DIV_CW: begin
        div_rem_init = '0;
        div_divisor  = REM_W'(kept_target_r);
        div_dividend = {ws_r, {FRAC_BITS{1'b0}}};
        div_steps    = STEP_W'(DIV_W);
      end
      default: begin
        div_rem_init = '0;
        div_divisor  = '0;
        div_dividend = '0;
        div_steps    = '0;
      end
    endcase
  end

  rws_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .dividend (div_dividend),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= CNT_W'(1);
      bsdf_cnt_r <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EMITTER_COUNT: emit_cnt_r <= cfg_wdata;
        CFG_BSDF_COUNT:    bsdf_cnt_r <= cfg_wdata;
        default:           emit_cnt_r <= emit_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tech_r   <= in_technique;
      cand_r   <= in_candidate_valid;
      own_r    <= in_own_pdf;
      other_r  <= in_other_pdf;
      delta_r  <= in_is_delta;
      target_r <= in_target_value;
      id_r     <= in_candidate_id;
      rnd_r    <= in_random_fraction;
      last_r   <= in_last;
    end
    if (cmd.load_prod) begin
      a_r <= PROD_W'(n_own) * PROD_W'(own_r);
      b_r <= PROD_W'(n_other) * PROD_W'(other_eff);
    end
    if (cmd.load_mis_one) begin
      mis_r <= MIS_W'(1) << FRAC_BITS;
    end else if (cmd.load_mis_div) begin
      mis_r <= {1'b0, div_quot[FRAC_BITS-1:0]};
    end
    if (cmd.load_scaled) begin
      scaled_r <= mis_prod[FRAC_BITS +: VAL_W];
    end
    if (cmd.load_rate) begin
      rate_r <= div_quot[VAL_W-1:0];
    end
    if (cmd.load_sum) begin
      sum_r <= sum_ext[VAL_W] ? '1 : sum_ext[VAL_W-1:0];
    end
    if (cmd.load_cmp) begin
      cmp_r <= (RND_W+VAL_W)'(rnd_r) * (RND_W+VAL_W)'(sum_r);
    end
    if (cmd.emit) begin
      out_id_r <= kept_id_r;
      out_ok_r <= keep_ok;
      out_cw_r <= keep_ok ? cw_val : '0;
      out_tw_r <= ws_r;
    end
  end

  always_comb begin
    ws_nxt          = ws_r;
    kept_id_nxt     = kept_id_r;
    kept_target_nxt = kept_target_r;
    kept_valid_nxt  = kept_valid_r;
    if (cmd.emit) begin
      ws_nxt          = '0;
      kept_id_nxt     = '0;
      kept_target_nxt = '0;
      kept_valid_nxt  = 1'b0;
    end else if (cmd.update) begin
      ws_nxt = sum_r;
      if (replace) begin
        kept_id_nxt     = id_r;
        kept_target_nxt = target_r;
        kept_valid_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r          <= '0;
      kept_id_r     <= '0;
      kept_target_r <= '0;
      kept_valid_r  <= 1'b0;
    end else begin
      ws_r          <= ws_nxt;
      kept_id_r     <= kept_id_nxt;
      kept_target_r <= kept_target_nxt;
      kept_valid_r  <= kept_valid_nxt;
    end
  end

  always_comb begin
    status.usable    = cand_r && (n_own != '0);
    status.a_zero    = (a_r == '0);
    status.b_zero    = (b_r == '0);
    status.div_busy  = div_busy;
    status.rate_zero = (rate_r == '0);
    status.last      = last_r;
    status.keep_ok   = keep_ok;
  end

  assign out_chosen_id           = out_id_r;
  assign out_chosen_valid        = out_ok_r;
  assign out_contribution_weight = out_cw_r;
  assign out_total_weight        = out_tw_r;

endmodule

`default_nettype wire

[rtl/rws_ctrl.sv]
// Controller of the reservoir sampler: sequences the datapath for each item
// and owns both handshakes. Depends on rws_pkg.
`default_nettype none

module rws_ctrl
  import rws_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.div_op = DIV_MIS;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PROD;
        end
      end
      S_PROD: begin
        if (!status.usable) begin
          state_nxt = S_FIN;
        end else begin
          cmd.load_prod = 1'b1;
          state_nxt     = S_MIS;
        end
      end
      S_MIS: begin
        if (status.a_zero) begin
          state_nxt = S_FIN;
        end else if (status.b_zero) begin
          cmd.load_mis_one = 1'b1;
          state_nxt        = S_SCALE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_MIS;
          state_nxt     = S_MIS_WAIT;
        end
      end
      S_MIS_WAIT: begin
        if (!status.div_busy) begin
          cmd.load_mis_div = 1'b1;
          state_nxt        = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.load_scaled = 1'b1;
        state_nxt       = S_RATE;
      end
      S_RATE: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RATE;
        state_nxt     = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (!status.div_busy) begin
          cmd.load_rate = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        if (status.rate_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.load_sum = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        cmd.load_cmp = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!status.last) begin
          state_nxt = S_IDLE;
        end else if (status.keep_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_CW;
          state_nxt     = S_CW_WAIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CW_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

endmodule

`default_nettype wire

[rtl/ris_weighted_reservoir_sampler_top.sv]
// Top level of the weighted reservoir sampler for resampled importance sampling.
// Depends on rws_pkg, rws_ctrl and rws_datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   technique .. last, one candidate
//   out      output     out_valid / out_ready chosen id, validity, weights
//   cfg      input      cfg_wr_en             index 0 emitter count, 1 BSDF count
//
// A usable candidate passes the bit-per-cycle divider twice, for the MIS weight (16 steps)
// and the rate (32 steps); the first is skipped when the other technique's term is zero.
// A candidate that is invalid, has a zero count or a zero own term skips both divisions.
// A last candidate adds the 48-step contribution division, which is skipped if none is kept.
// Reset is synchronous and clears the reservoir and sets both counts to one.
// A waiting result does not stop the next item; only the next result waits.
`default_nettype none

module ris_weighted_reservoir_sampler_top
  import rws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_technique,
  input  wire logic             in_candidate_valid,
  input  wire logic [VAL_W-1:0] in_own_pdf,
  input  wire logic [VAL_W-1:0] in_other_pdf,
  input  wire logic             in_is_delta,
  input  wire logic [VAL_W-1:0] in_target_value,
  input  wire logic [ID_W-1:0]  in_candidate_id,
  input  wire logic [RND_W-1:0] in_random_fraction,
  input  wire logic             in_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ID_W-1:0]       out_chosen_id,
  output logic                  out_chosen_valid,
  output logic [VAL_W-1:0]      out_contribution_weight,
  output logic [VAL_W-1:0]      out_total_weight
);

  cmd_t    cmd;
  status_t status;

  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rws_datapath u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_technique            (in_technique),
    .in_candidate_valid      (in_candidate_valid),
    .in_own_pdf              (in_own_pdf),
    .in_other_pdf            (in_other_pdf),
    .in_is_delta             (in_is_delta),
    .in_target_value         (in_target_value),
    .in_candidate_id         (in_candidate_id),
    .in_random_fraction      (in_random_fraction),
    .in_last                 (in_last),
    .cmd                     (cmd),
    .status                  (status),
    .out_chosen_id           (out_chosen_id),
    .out_chosen_valid        (out_chosen_valid),
    .out_contribution_weight (out_contribution_weight),
    .out_total_weight        (out_total_weight)
  );

endmodule

`default_nettype wire

[rtl/rws_checker.sv]
// Port-level checks for the weighted reservoir sampler and their binding to
// the top level. Depends on rws_pkg.
`default_nettype none

module rws_checker
  import rws_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ID_W-1:0]  out_chosen_id,
  input wire logic             out_chosen_valid,
  input wire logic [VAL_W-1:0] out_contribution_weight,
  input wire logic [VAL_W-1:0] out_total_weight
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_id)
      && $stable(out_chosen_valid) && $stable(out_contribution_weight)
      && $stable(out_total_weight))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while the previous one is in work");

  // An invalid result carries no contribution weight.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chosen_valid |-> out_contribution_weight == '0)
    else $error("contribution weight set on an invalid result");

  // A kept candidate implies a positive weight sum.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chosen_valid |-> out_total_weight != '0)
    else $error("valid result with zero weight sum");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ris_weighted_reservoir_sampler_top rws_checker u_rws_checker (.*);

`default_nettype wire

[verif/rws_pick_checker.sv]
// Result checker for the weighted reservoir sampler: keeps its own copy of the
// reservoir and of both sample counts, predicts each pixel result and compares.
// Depends on rws_pkg for widths and register codes.
`timescale 1ns / 100ps

module rws_pick_checker
  import rws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  cfg_reg_t         cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_technique,
  input  logic             in_candidate_valid,
  input  logic [VAL_W-1:0] in_own_pdf,
  input  logic [VAL_W-1:0] in_other_pdf,
  input  logic             in_is_delta,
  input  logic [VAL_W-1:0] in_target_value,
  input  logic [ID_W-1:0]  in_candidate_id,
  input  logic [RND_W-1:0] in_random_fraction,
  input  logic             in_last,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [ID_W-1:0]  out_chosen_id,
  input  logic             out_chosen_valid,
  input  logic [VAL_W-1:0] out_contribution_weight,
  input  logic [VAL_W-1:0] out_total_weight,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             ok;
    logic [VAL_W-1:0] contribution;
    logic [VAL_W-1:0] total;
  } pick_t;

  logic [CNT_W-1:0] emitter_count;
  logic [CNT_W-1:0] bsdf_count;
  logic [VAL_W-1:0] weight_sum;
  logic [VAL_W-1:0] kept_target;
  logic [ID_W-1:0]  kept_id;
  logic             kept_valid;
  pick_t            expected_picks[$];

  function automatic logic [VAL_W-1:0] q16_div(input logic [63:0] num,
                                               input logic [63:0] den);
    logic [63:0] q;
    q = num / den;
    if (q >= (64'd1 << (VAL_W - FRAC_BITS)))
      return '1;
    q = (num << FRAC_BITS) / den;
    return q[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic [63:0] n_own, n_other, own, other, target, a, s, mis, r, sum, rnd;
    pick_t       got, want;
    if (!rst_n) begin
      emitter_count = CNT_W'(1);
      bsdf_count = CNT_W'(1);
      weight_sum = '0;
      kept_target = '0;
      kept_id = '0;
      kept_valid = 1'b0;
      expected_picks.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_EMITTER_COUNT: emitter_count = cfg_wdata;
          CFG_BSDF_COUNT:    bsdf_count = cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = '{out_chosen_id, out_chosen_valid, out_contribution_weight,
                out_total_weight};
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: id %h valid %b cw %h total %h",
                     $time, got.id, got.ok, got.contribution, got.total);
        end else begin
          want = expected_picks.pop_front();
          if (got.id !== want.id || got.ok !== want.ok ||
              got.contribution !== want.contribution || got.total !== want.total) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected id %h valid %b cw %h total %h,",
                        " got id %h valid %b cw %h total %h"},
                       $time, want.id, want.ok, want.contribution, want.total,
                       got.id, got.ok, got.contribution, got.total);
          end
        end
      end

      if (in_valid && in_ready) begin
        n_own = 64'(in_technique ? bsdf_count : emitter_count);
        n_other = 64'(in_technique ? emitter_count : bsdf_count);
        own = 64'(in_own_pdf);
        other = (in_technique && in_is_delta) ? 64'd0 : 64'(in_other_pdf);
        target = 64'(in_target_value);
        rnd = 64'(in_random_fraction);
        if (in_candidate_valid && n_own != 0) begin
          a = n_own * own;
          s = a + n_other * other;
          mis = (s != 0) ? 64'(q16_div(a, s)) : 64'd0;
          r = ((mis * target) / n_own) >> FRAC_BITS;
          if (r != 0) begin
            sum = 64'(weight_sum) + r;
            if (sum > 64'hFFFF_FFFF)
              sum = 64'hFFFF_FFFF;
            weight_sum = sum[VAL_W-1:0];
            if (rnd * sum < (r << 16)) begin
              kept_id = in_candidate_id;
              kept_target = in_target_value;
              kept_valid = 1'b1;
            end
          end
        end
        if (in_last) begin
          want.id = kept_id;
          want.ok = kept_valid && kept_target != '0;
          want.contribution = want.ok ? q16_div(64'(weight_sum), 64'(kept_target)) : '0;
          want.total = weight_sum;
          expected_picks.push_back(want);
          weight_sum = '0;
          kept_target = '0;
          kept_id = '0;
          kept_valid = 1'b0;
        end
      end
      pending = expected_picks.size();
    end
  end

endmodule

[verif/ris_weighted_reservoir_sampler_top_tb.sv]
// Testbench top for the weighted reservoir sampler: clock, reset, directed and
// random candidate streams under several sample-count settings, and the verdict.
// Depends on rws_pkg, the sampler RTL and rws_pick_checker.
`timescale 1ns / 100ps

module ris_weighted_reservoir_sampler_top_tb;
  import rws_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 150;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic             technique;
    logic             cand_valid;
    logic [VAL_W-1:0] own_pdf;
    logic [VAL_W-1:0] other_pdf;
    logic             is_delta;
    logic [VAL_W-1:0] target;
    logic [ID_W-1:0]  id;
    logic [RND_W-1:0] rnd;
    logic             last;
  } cand_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  cfg_reg_t         cfg_index;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             in_technique;
  logic             in_candidate_valid;
  logic [VAL_W-1:0] in_own_pdf;
  logic [VAL_W-1:0] in_other_pdf;
  logic             in_is_delta;
  logic [VAL_W-1:0] in_target_value;
  logic [ID_W-1:0]  in_candidate_id;
  logic [RND_W-1:0] in_random_fraction;
  logic             in_last;
  logic             out_valid;
  logic             out_ready;
  logic [ID_W-1:0]  out_chosen_id;
  logic             out_chosen_valid;
  logic [VAL_W-1:0] out_contribution_weight;
  logic [VAL_W-1:0] out_total_weight;
  int               mismatches;
  int               pending;

  ris_weighted_reservoir_sampler_top dut (.*);

  rws_pick_checker pick_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] q16_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      4:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_0100, 32'h0010_0000);
    endcase
  endfunction

  function automatic cand_t random_candidate(input logic last_flag);
    cand_t c;
    c.technique = 1'($urandom_range(0, 1));
    c.cand_valid = ($urandom_range(0, 9) != 0);
    c.own_pdf = q16_value();
    c.other_pdf = q16_value();
    c.is_delta = ($urandom_range(0, 3) == 0);
    c.target = q16_value();
    c.id = ID_W'($urandom);
    case ($urandom_range(0, 9))
      0:       c.rnd = '0;
      1:       c.rnd = '1;
      default: c.rnd = RND_W'($urandom);
    endcase
    c.last = last_flag;
    return c;
  endfunction

  function automatic cand_t cand(input logic tech, input logic ok,
                                 input logic [VAL_W-1:0] own, input logic [VAL_W-1:0] other,
                                 input logic delta, input logic [VAL_W-1:0] tgt,
                                 input logic [ID_W-1:0] id, input logic [RND_W-1:0] rnd,
                                 input logic last);
    return '{tech, ok, own, other, delta, tgt, id, rnd, last};
  endfunction

  task automatic send_item(input cand_t c, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_technique <= c.technique;
    in_candidate_valid <= c.cand_valid;
    in_own_pdf <= c.own_pdf;
    in_other_pdf <= c.other_pdf;
    in_is_delta <= c.is_delta;
    in_target_value <= c.target;
    in_candidate_id <= c.id;
    in_random_fraction <= c.rnd;
    in_last <= c.last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_counts(input logic [CNT_W-1:0] emitter, input logic [CNT_W-1:0] bsdf);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_EMITTER_COUNT;
    cfg_wdata <= emitter;
    @(negedge clk);
    cfg_index <= CFG_BSDF_COUNT;
    cfg_wdata <= bsdf;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : out_pacing
    int stall, run;
    out_ready = 1'b0;
    stall = 0;
    run = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && run == 0) begin
        stall = idle_len();
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        run--;
      end
    end
  end

  initial begin : stimulus
    cand_t            c;
    cand_t            directed[$];
    logic [CNT_W-1:0] emitter_plan[PHASES];
    logic [CNT_W-1:0] bsdf_plan[PHASES];
    int               accepted, len;
    logic             burst;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_EMITTER_COUNT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_technique = 1'b0;
    in_candidate_valid = 1'b0;
    in_own_pdf = '0;
    in_other_pdf = '0;
    in_is_delta = 1'b0;
    in_target_value = '0;
    in_candidate_id = '0;
    in_random_fraction = '0;
    in_last = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed = '{
      cand(1'b0, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0002_0000, 16'h1234, 16'h0000, 1'b0),
      cand(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0),
      cand(1'b1, 1'b1, 32'h0000_8000, 32'hFFFF_FFFF, 1'b1, 32'h0003_0000, 16'hA5A5, 16'h8000, 1'b1),
      cand(1'b0, 1'b1, 32'h0000_4000, 32'h0000_4000, 1'b1, 32'h0001_0000, 16'h0001, 16'h0001, 1'b0),
      cand(1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h0002, 16'h0000, 1'b0),
      cand(1'b0, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0000_0001, 16'h0003, 16'h0000, 1'b0),
      cand(1'b1, 1'b0, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0001_0000, 16'h0004, 16'h0000, 1'b1),
      cand(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h5A5A, 16'h0000, 1'b1),
      cand(1'b0, 1'b1, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h0010, 16'h0000, 1'b0),
      cand(1'b1, 1'b1, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h0011, 16'hFFFF, 1'b0),
      cand(1'b0, 1'b1, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h0012, 16'h7FFF, 1'b1),
      cand(1'b0, 1'b1, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 16'h0020, 16'h0000, 1'b0),
      cand(1'b1, 1'b1, 32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0000_0002, 16'h0021, 16'h0000, 1'b1)
    };
    foreach (directed[i])
      send_item(directed[i], idle_len());

    drain();
    set_counts(8'd0, 8'd255);
    send_item(cand(1'b0, 1'b1, 32'h0001_0000, 32'h0000_1000, 1'b0, 32'h0004_0000,
                   16'h0030, 16'h0000, 1'b0), 0);
    send_item(cand(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                   16'h0031, 16'h0000, 1'b1), 0);
    send_item(cand(1'b0, 1'b1, 32'h0002_0000, 32'h0001_0000, 1'b0, 32'h0001_0000,
                   16'h0032, 16'h0000, 1'b1), idle_len());

    drain();
    set_counts(8'd255, 8'd0);
    send_item(cand(1'b1, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0004_0000,
                   16'h0040, 16'h0000, 1'b0), 0);
    send_item(cand(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h00FF_0000,
                   16'h0041, 16'h0000, 1'b1), 0);

    emitter_plan = '{8'd3, 8'd255, 8'd0, 8'd17, 8'd0, 8'd0, 8'd1};
    bsdf_plan = '{8'd5, 8'd255, 8'd7, 8'd0, 8'd0, 8'd0, 8'd2};
    emitter_plan[4] = CNT_W'($urandom_range(1, 254));
    bsdf_plan[4] = CNT_W'($urandom_range(1, 254));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_counts(emitter_plan[p], bsdf_plan[p]);
      accepted = 0;
      while (accepted < PHASE_ITEMS) begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          c = random_candidate(i == len - 1);
          if (c.cand_valid)
            accepted++;
          send_item(c, burst ? 0 : idle_len());
        end
      end
    end

    drain();
    if (mismatches == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[ris_weighted_reservoir_sampler_top.f]
rtl/rws_pkg.sv
rtl/rws_divider.sv
rtl/rws_datapath.sv
rtl/rws_ctrl.sv
rtl/ris_weighted_reservoir_sampler_top.sv
rtl/rws_checker.sv
verif/rws_pick_checker.sv
verif/ris_weighted_reservoir_sampler_top_tb.sv
